// File: hdl/nlc_pkg.sv
// Shared definitions for the numeric literal classifier.
// Holds character codes, result kind codes, the scanner state type and
// character test functions. No dependencies.
`timescale 1ns / 1ps

package nlc_pkg;

  // Result kind codes.
  localparam logic [2:0] KIND_NONE   = 3'd0;
  localparam logic [2:0] KIND_HEX    = 3'd1;
  localparam logic [2:0] KIND_INT    = 3'd2;
  localparam logic [2:0] KIND_FLOAT  = 3'd3;
  localparam logic [2:0] KIND_DOUBLE = 3'd4;
  localparam logic [2:0] KIND_ARITH  = 3'd5;

  // Exponent tracking codes.
  localparam logic [1:0] EXP_NONE       = 2'd0;
  localparam logic [1:0] EXP_AFTER_E    = 2'd1;
  localparam logic [1:0] EXP_AFTER_SIGN = 2'd2;

  // Character codes.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_F   = 8'h46;
  localparam logic [7:0] CH_LC_E   = 8'h65;
  localparam logic [7:0] CH_UC_E   = 8'h45;
  localparam logic [7:0] CH_LC_X   = 8'h78;
  localparam logic [7:0] CH_UC_X   = 8'h58;

  // Position counter saturation value.
  localparam logic [1:0] POS_MAX = 2'd3;

  // Scanner state: position counter, one flag per check and the exponent phase.
  typedef struct packed {
    logic [1:0] pos;
    logic       body_seen;
    logic       int_alive;
    logic       float_alive;
    logic       float_dot_seen;
    logic       dbl_alive;
    logic       dbl_dot_seen;
    logic       exp_seen;
    logic [1:0] exp_phase;
    logic       hex_alive;
    logic       op_seen;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    pos:            2'd0,
    body_seen:      1'b0,
    int_alive:      1'b1,
    float_alive:    1'b1,
    float_dot_seen: 1'b0,
    dbl_alive:      1'b1,
    dbl_dot_seen:   1'b0,
    exp_seen:       1'b0,
    exp_phase:      EXP_NONE,
    hex_alive:      1'b1,
    op_seen:        1'b0
  };

  function automatic logic dec_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic hex_digit(input logic [7:0] c);
    return dec_digit(c) || ((c >= CH_LC_A) && (c <= CH_LC_F)) ||
           ((c >= CH_UC_A) && (c <= CH_UC_F));
  endfunction

  function automatic logic sign_char(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS);
  endfunction

  function automatic logic op_char(input logic [7:0] c);
    return sign_char(c) || (c == CH_STAR) || (c == CH_SLASH) ||
           (c == CH_CARET) || (c == CH_PCT) || (c == CH_LPAREN) ||
           (c == CH_RPAREN);
  endfunction

endpackage

// File: hdl/numeric_literal_classifier.sv
// Numeric literal classifier, top level: input register, scanner, result register.
// A zero byte ends a string; its result is loaded into the result register when it leaves the input register.
// Throughput is one byte per cycle while no terminator is held back by a full result register.
// A result waiting in the output register holds back the next terminator byte.
// Synchronous reset clears both registers' valid flags and all scanner state.
// Depends on nlc_pkg and nlc_scan.
`timescale 1ns / 1ps

module numeric_literal_classifier (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       is_number,
  output logic [2:0] kind
);
  import nlc_pkg::*;

  logic       in_full;
  logic [7:0] in_byte;
  logic       term;
  logic       advance;
  logic [2:0] scan_kind;

  // A held byte moves on unless it is a terminator facing a full result register that is not being read.
  assign term     = (in_byte == CH_NUL);
  assign advance  = in_full && (!term || !out_valid || out_ready);
  assign in_ready = !in_full || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= char_byte;
    end
  end

  nlc_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .char_byte (in_byte),
    .kind      (scan_kind)
  );

  // Result register, loaded by a terminator request.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && term) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && term) begin
      kind      <= scan_kind;
      is_number <= (scan_kind != KIND_NONE);
    end
  end

endmodule

// File: hdl/nlc_scan.sv
// Per-byte scanner state of the numeric literal classifier.
// Updates all class checks for one byte a cycle while step is high, and decodes the class.
// Depends on nlc_pkg.
`timescale 1ns / 1ps

module nlc_scan (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] char_byte,
  output logic [2:0] kind
);
  import nlc_pkg::*;

  scan_state_t st;
  scan_state_t st_next;
  logic        body_char;

  // Bytes other than a leading sign belong to the number body.
  assign body_char = !((st.pos == 2'd0) && sign_char(char_byte));

  // Next state for one byte; the terminator returns to the reset state.
  always_comb begin
    st_next = st;
    if (char_byte == CH_NUL) begin
      st_next = SCAN_RESET;
    end else begin
      // Hex form: '0', then x or X, then hex digits.
      case (st.pos)
        2'd0: if (char_byte != CH_ZERO) st_next.hex_alive = 1'b0;
        2'd1: if ((char_byte != CH_LC_X) && (char_byte != CH_UC_X)) st_next.hex_alive = 1'b0;
        default: if (!hex_digit(char_byte)) st_next.hex_alive = 1'b0;
      endcase

      if (op_char(char_byte)) st_next.op_seen = 1'b1;

      if (body_char) begin
        st_next.body_seen = 1'b1;
        if (!dec_digit(char_byte)) st_next.int_alive = 1'b0;

        // Plain decimal with one dot.
        if (char_byte == CH_DOT) begin
          if (st.float_dot_seen) st_next.float_alive = 1'b0;
          else st_next.float_dot_seen = 1'b1;
        end else if (!dec_digit(char_byte)) begin
          st_next.float_alive = 1'b0;
        end

        // Scientific notation.
        if (st.dbl_alive) begin
          if (st.exp_phase == EXP_AFTER_E) begin
            if (sign_char(char_byte)) begin
              st_next.exp_phase = EXP_AFTER_SIGN;
            end else begin
              if (!dec_digit(char_byte)) st_next.dbl_alive = 1'b0;
              st_next.exp_phase = EXP_NONE;
            end
          end else if (st.exp_phase == EXP_AFTER_SIGN) begin
            if (!dec_digit(char_byte)) st_next.dbl_alive = 1'b0;
            st_next.exp_phase = EXP_NONE;
          end else if (char_byte == CH_DOT) begin
            if (st.dbl_dot_seen || st.exp_seen) st_next.dbl_alive = 1'b0;
            else st_next.dbl_dot_seen = 1'b1;
          end else if ((char_byte == CH_LC_E) || (char_byte == CH_UC_E)) begin
            if (st.exp_seen) begin
              st_next.dbl_alive = 1'b0;
            end else begin
              st_next.exp_seen  = 1'b1;
              st_next.exp_phase = EXP_AFTER_E;
            end
          end else if (!dec_digit(char_byte)) begin
            st_next.dbl_alive = 1'b0;
          end
        end
      end

      if (st.pos != POS_MAX) st_next.pos = st.pos + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= SCAN_RESET;
    end else if (step) begin
      st <= st_next;
    end
  end

  // Class decode in priority order from the state before the terminator.
  always_comb begin
    if (st.hex_alive && (st.pos == POS_MAX)) begin
      kind = KIND_HEX;
    end else if (st.body_seen && st.int_alive) begin
      kind = KIND_INT;
    end else if (st.body_seen && st.float_alive && st.float_dot_seen) begin
      kind = KIND_FLOAT;
    end else if (st.body_seen && st.dbl_alive && (st.exp_phase == EXP_NONE) &&
                 (st.dbl_dot_seen || st.exp_seen)) begin
      kind = KIND_DOUBLE;
    end else if (st.op_seen) begin
      kind = KIND_ARITH;
    end else begin
      kind = KIND_NONE;
    end
  end

endmodule
